>>> design/qed_pkg.sv
// ----------------------------------------------------------------------------
// qed_pkg: shared types and constants of the quadrature edge decoder
// Item layouts, command codes, decoder state and the 4x step table.
// ----------------------------------------------------------------------------
package qed_pkg;

  localparam int CountW    = 32;
  localparam int AbW       = 2;
  localparam int StepW     = 2;
  localparam int InTdataW  = 8;
  localparam int OutTdataW = 104;

  // Command codes carried in the input tuser bit.
  localparam logic CMD_EDGE  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // Edge phase codes.
  localparam logic PHASE_A = 1'b0;
  localparam logic PHASE_B = 1'b1;

  // Toggle masks on the A<<1|B state.
  localparam logic [AbW-1:0] TOGGLE_A = 2'b10;
  localparam logic [AbW-1:0] TOGGLE_B = 2'b01;

  // Step codes.
  localparam logic signed [StepW-1:0] STEP_NONE = 2'sb00;
  localparam logic signed [StepW-1:0] STEP_FWD  = 2'sb01;
  localparam logic signed [StepW-1:0] STEP_REV  = 2'sb11;

  // One input item.
  typedef struct packed {
    logic                    cmd;
    logic                    edge_phase;
    logic signed [StepW-1:0] expected_direction;
    logic [AbW-1:0]          start_ab;
  } qed_item_t;

  // Decoder state.
  typedef struct packed {
    logic [AbW-1:0]    phase;
    logic [CountW-1:0] position;
    logic [CountW-1:0] invalid;
    logic [CountW-1:0] resync;
  } qed_state_t;

  // Standard 4x quadrature table, indexed by old_ab*4 + new_ab.
  function automatic logic signed [StepW-1:0] step_lookup(input logic [3:0] idx);
    logic signed [StepW-1:0] s;
    unique case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: s = STEP_FWD;
      4'd2, 4'd4, 4'd11, 4'd13: s = STEP_REV;
      default: s = STEP_NONE;
    endcase
    return s;
  endfunction

endpackage

>>> design/qed_in_stage.sv
// ----------------------------------------------------------------------------
// qed_in_stage: input register of the decoder
// Captures one item from the input stream and holds it until it is decoded.
// ----------------------------------------------------------------------------
module qed_in_stage (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [qed_pkg::InTdataW-1:0]  in_tdata,  // edge_phase, expected_direction[1:0], start_ab[1:0], zero pad
  input  logic                          in_tuser,  // cmd
  input  logic                          advance,
  output logic                          item_valid,
  output qed_pkg::qed_item_t            item
);
  import qed_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  qed_item_t item_r;

  // The register is free when empty or when its item moves on this cycle.
  assign in_tready = !valid_r || advance;
  assign valid_nxt = in_tready ? in_tvalid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload capture, no reset needed.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.cmd                <= in_tuser;
      item_r.edge_phase         <= in_tdata[0];
      item_r.expected_direction <= in_tdata[2:1];
      item_r.start_ab           <= in_tdata[4:3];
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

>>> design/qed_decode.sv
// ----------------------------------------------------------------------------
// qed_decode: step decode and counter update
// Computes the next decoder state and the applied step for one item.
// ----------------------------------------------------------------------------
module qed_decode (
  input  qed_pkg::qed_state_t             cur,
  input  qed_pkg::qed_item_t              item,
  input  logic                            invert,
  output qed_pkg::qed_state_t             nxt,
  output logic signed [qed_pkg::StepW-1:0] step
);
  import qed_pkg::*;

  logic [AbW-1:0]          toggle;
  logic [AbW-1:0]          new_ab;
  logic signed [StepW-1:0] raw_step;
  logic signed [StepW-1:0] signed_step;
  logic signed [StepW-1:0] expected;
  logic                    illegal;
  logic                    force_dir;
  logic signed [StepW-1:0] edge_step;

  // Flip the toggled phase bit and look up the transition.
  assign toggle   = (item.edge_phase == PHASE_B) ? TOGGLE_B : TOGGLE_A;
  assign new_ab   = cur.phase ^ toggle;
  assign raw_step = step_lookup({cur.phase, new_ab});
  assign signed_step = invert ? -raw_step : raw_step;

  // The pattern for -2 reads by its sign and acts as reverse.
  assign expected = {item.expected_direction[1],
                     item.expected_direction[1] | item.expected_direction[0]};

  assign illegal   = (signed_step == STEP_NONE);
  assign force_dir = !illegal && (expected != STEP_NONE) && (signed_step != expected);
  assign edge_step = force_dir ? expected : signed_step;

  // Clear loads the start state; an edge updates counters.
  always_comb begin
    if (item.cmd == CMD_CLEAR) begin
      nxt.phase    = item.start_ab;
      nxt.position = '0;
      nxt.invalid  = '0;
      nxt.resync   = '0;
      step         = STEP_NONE;
    end else begin
      nxt.phase    = new_ab;
      nxt.position = cur.position + {{(CountW-StepW){edge_step[StepW-1]}}, edge_step};
      nxt.invalid  = cur.invalid + {{(CountW-1){1'b0}}, illegal};
      nxt.resync   = cur.resync + {{(CountW-1){1'b0}}, force_dir};
      step         = edge_step;
    end
  end

endmodule

>>> design/quadrature_edge_decoder_resync.sv
// ----------------------------------------------------------------------------
// quadrature_edge_decoder_resync: edge-driven 4x quadrature decoder
// Tracks phase state, position, invalid and resync counts from edge items.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Content
//  in_     | input     | in_tvalid/in_tready  | edge or clear item
//  out_    | output    | out_tvalid/out_tready| counters after each item
//  cfg_    | input     | cfg_valid/cfg_ready  | invert_direction bit
//
// Each item passes from the input register through the decode step into the
// result register; one item per cycle while the output is not stalled.
// The state update fits between those two registers, so the throughput is set
// by that single decode step. Reset clears state, counters and valid flags.
// A stalled output holds its item; an empty input register still takes one item while it waits.
// ----------------------------------------------------------------------------
module quadrature_edge_decoder_resync (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [qed_pkg::InTdataW-1:0]   in_tdata,   // edge_phase, expected_direction[1:0], start_ab[1:0], zero pad
  input  logic                           in_tuser,   // cmd
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [qed_pkg::OutTdataW-1:0]  out_tdata,  // position[31:0], step_applied[1:0], invalid_total[31:0], resync_total[31:0], phase_ab[1:0], zero pad
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_data
);
  import qed_pkg::*;

  logic                    item_valid;
  qed_item_t               item;
  logic                    advance;
  qed_state_t              state_r;
  qed_state_t              state_nxt;
  logic signed [StepW-1:0] step;
  logic                    invert_r;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic [OutTdataW-1:0]    out_data_r;

  qed_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  qed_decode u_dec (
    .cur    (state_r),
    .item   (item),
    .invert (invert_r),
    .nxt    (state_nxt),
    .step   (step)
  );

  // An item is decoded when the result register is free or being drained.
  assign advance       = item_valid && (!out_valid_r || out_tready);
  assign out_valid_nxt = advance || (out_valid_r && !out_tready);

  // Configuration register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_r <= 1'b0;
    end else if (cfg_valid) begin
      invert_r <= cfg_data;
    end
  end

  // Decoder state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {(OutTdataW - (3*CountW + StepW + AbW))'(0),
                     state_nxt.phase, state_nxt.resync, state_nxt.invalid,
                     step, state_nxt.position};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> design/qed_checker.sv
// ----------------------------------------------------------------------------
// qed_checker: port-level checks of the quadrature edge decoder
// Watches the result stream for holding, step codes and counter continuity.
// ----------------------------------------------------------------------------
module qed_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [qed_pkg::OutTdataW-1:0] out_tdata
);
  import qed_pkg::*;

  logic [CountW-1:0]       pos;
  logic signed [StepW-1:0] stp;
  logic [CountW-1:0]       inv;
  logic [CountW-1:0]       rsy;
  logic                    prev_valid_r;
  logic [CountW-1:0]       prev_pos_r;
  logic [CountW-1:0]       prev_rsy_r;
  logic                    is_clear;
  logic                    pos_ok;
  logic                    rsy_ok;

  assign pos = out_tdata[CountW-1:0];
  assign stp = out_tdata[CountW+StepW-1:CountW];
  assign inv = out_tdata[2*CountW+StepW-1:CountW+StepW];
  assign rsy = out_tdata[3*CountW+StepW-1:2*CountW+StepW];

  // Remember the last delivered item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_valid_r <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      prev_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_tvalid && out_tready) begin
      prev_pos_r <= pos;
      prev_rsy_r <= rsy;
    end
  end

  assign is_clear = (stp == STEP_NONE) && (pos == '0) && (inv == '0) && (rsy == '0);
  assign pos_ok   = (pos == prev_pos_r + {{(CountW-StepW){stp[StepW-1]}}, stp});
  assign rsy_ok   = (rsy == prev_rsy_r) || (rsy == prev_rsy_r + CountW'(1));

  // A stalled result holds its item.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  // The applied step is never the code for minus two.
  a_step_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> stp != 2'sb10)
    else $error("illegal step code on output");

  // Position moves by exactly the applied step, unless a clear reset it.
  a_pos_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && prev_valid_r |-> pos_ok || is_clear)
    else $error("position does not follow the applied step");

  // The resync count grows by at most one per item, unless cleared.
  a_rsy_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && prev_valid_r |-> rsy_ok || is_clear)
    else $error("resync count jumped");

  // Nothing is delivered right after reset, and offered input is accepted then.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && (in_tready || !in_tvalid || in_tready))
    else $error("result valid right after reset");

endmodule

bind quadrature_edge_decoder_resync qed_checker u_qed_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
